// ----- hw/rtl/wtls_pkg.sv -----
// Shared types and constants for the weighted three-level scheduler.
// Used by the controller, the datapath and the top level.
`default_nettype none
package wtls_pkg;
  localparam logic [1:0] CMD_ADD_READY   = 2'd0;
  localparam logic [1:0] CMD_ADD_BLOCKED = 2'd1;
  localparam logic [1:0] CMD_SCHEDULE    = 2'd2;
  localparam logic [1:0] CMD_ADVANCE     = 2'd3;
  localparam logic [1:0] LVL_NONE   = 2'd0;
  localparam logic [1:0] LVL_HIGH   = 2'd1;
  localparam logic [1:0] LVL_MEDIUM = 2'd2;
  localparam logic [1:0] LVL_LOW    = 2'd3;
  localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] TICK_RESET = 32'd1000000;
  localparam logic [2:0] SLOT_COUNT = 3'd7;
  localparam logic [2:0] HIGH_SLOTS = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the item and clear the per-item flags
    logic exec;      // run add_ready, add_blocked or advance_time
    logic tick;      // add the tick amount to the clock
    logic scan_init; // start the blocked-store scan at the newest entry
    logic scan_step; // examine one blocked entry
    logic compact;   // move one survivor down
    logic grant;     // pop one id by the slot order
    logic result;    // drive the result strobe
  } wtls_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic compact_done;
  } wtls_sts_t;
endpackage
`default_nettype wire

// ----- hw/rtl/wtls_ctrl.sv -----
// Controller state machine of the weighted three-level scheduler.
// Depends on wtls_pkg for the command and status structs.
`default_nettype none
module wtls_ctrl import wtls_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire logic [1:0] command,
  input  wire wtls_sts_t sts,
  output logic           busy,
  output wtls_cmd_t      cmd
);
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EXEC    = 3'd1;
  localparam logic [2:0] S_TICK    = 3'd2;
  localparam logic [2:0] S_SCAN    = 3'd3;
  localparam logic [2:0] S_COMPACT = 3'd4;
  localparam logic [2:0] S_GRANT   = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  logic [2:0] state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd = '0;
    busy = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = (command == CMD_SCHEDULE) ? S_TICK : S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_next = S_DONE;
      end
      S_TICK: begin
        cmd.tick = 1'b1;
        cmd.scan_init = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_next = S_COMPACT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_COMPACT: begin
        if (sts.compact_done) begin
          state_next = S_GRANT;
        end else begin
          cmd.compact = 1'b1;
        end
      end
      S_GRANT: begin
        cmd.grant = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.result = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ----- hw/rtl/wtls_dp.sv -----
// Datapath of the weighted three-level scheduler: ready queues, blocked
// store, clock and slot counter. Depends on wtls_pkg.
`default_nettype none
module wtls_dp import wtls_pkg::*; #(
  parameter int READY_DEPTH   = 16,
  parameter int BLOCKED_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire wtls_cmd_t   cmd,
  output wtls_sts_t        sts,
  input  wire logic        tick_we,
  input  wire logic [31:0] tick_wdata,
  input  wire logic [1:0]  command,
  input  wire logic [15:0] process_id,
  input  wire logic [1:0]  priority_req,
  input  wire logic [47:0] wake_time,
  input  wire logic [31:0] time_amount,
  output logic             result_valid,
  output logic             grant_valid,
  output logic [15:0]      granted_id,
  output logic [1:0]       granted_level,
  output logic [4:0]       released_count,
  output logic             dropped,
  output logic             all_empty
);
  localparam int RAW = (READY_DEPTH > 1) ? $clog2(READY_DEPTH) : 1;
  localparam int RCW = $clog2(READY_DEPTH + 1);
  localparam int BAW = (BLOCKED_DEPTH > 1) ? $clog2(BLOCKED_DEPTH) : 1;
  localparam int BCW = $clog2(BLOCKED_DEPTH + 1);
  localparam logic [RCW-1:0] RFULL = RCW'(READY_DEPTH);
  localparam logic [BCW-1:0] BFULL = BCW'(BLOCKED_DEPTH);
  localparam logic [RAW-1:0] RLAST = RAW'(READY_DEPTH - 1);

  // Ready queues, blocked store and the gone flags of one scan.
  logic [15:0]     rq_mem [3][READY_DEPTH];
  logic [RAW-1:0]  rq_head [3];
  logic [RCW-1:0]  rq_cnt [3];
  logic [15:0]     bs_id [BLOCKED_DEPTH];
  logic [1:0]      bs_lvl [BLOCKED_DEPTH];
  logic [47:0]     bs_wake [BLOCKED_DEPTH];
  logic [BLOCKED_DEPTH-1:0] gone;
  logic [BCW-1:0]  bcount;
  logic [47:0]     cur_time;
  logic [2:0]      slot;
  logic [31:0]     tick_amount;

  // Captured item and per-item flags.
  logic [1:0]  cmd_r;
  logic [15:0] pid_r;
  logic [1:0]  prio_r;
  logic [47:0] wake_r;
  logic [31:0] amt_r;
  logic        lost;
  logic [4:0]  landed;
  logic        granted;
  logic [15:0] gid;
  logic [1:0]  glvl;

  // Scan and compaction indices, and the store count at the start of the scan.
  logic [BCW-1:0] scan_i;
  logic [BCW-1:0] scan_n;
  logic [BCW-1:0] rd_i;
  logic [BCW-1:0] wr_i;

  // Clock add with saturation.
  logic [31:0] add_amt;
  logic [48:0] time_sum;
  assign add_amt  = cmd.tick ? tick_amount : amt_r;
  assign time_sum = {1'b0, cur_time} + {17'd0, add_amt};

  // One scanned entry.
  logic [BAW-1:0] sk;
  logic [1:0]     s_lvl;
  logic [1:0]     s_q;
  logic           s_exp;
  assign sk    = BAW'(scan_i - BCW'(1));
  assign s_lvl = bs_lvl[sk];
  assign s_q   = s_lvl - 2'd1;
  assign s_exp = bs_wake[sk] <= cur_time;

  // Push for add_ready.
  logic [1:0] a_q;
  assign a_q = prio_r - 2'd1;

  // Grant selection by the slot order.
  logic [1:0] g_lvl;
  always_comb begin
    g_lvl = LVL_NONE;
    if (slot < HIGH_SLOTS) begin
      if      (rq_cnt[0] != '0) g_lvl = LVL_HIGH;
      else if (rq_cnt[1] != '0) g_lvl = LVL_MEDIUM;
      else if (rq_cnt[2] != '0) g_lvl = LVL_LOW;
    end else begin
      if      (rq_cnt[1] != '0) g_lvl = LVL_MEDIUM;
      else if (rq_cnt[2] != '0) g_lvl = LVL_LOW;
      else if (rq_cnt[0] != '0) g_lvl = LVL_HIGH;
    end
  end
  logic [1:0] g_q;
  assign g_q = g_lvl - 2'd1;

  assign sts.scan_done    = (scan_i == '0);
  assign sts.compact_done = (rd_i == scan_n);

  // Control state: counters, pointers, flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int q = 0; q < 3; q++) begin
        rq_head[q] <= '0;
        rq_cnt[q]  <= '0;
      end
      bcount <= '0;
      cur_time <= '0;
      slot <= '0;
      tick_amount <= TICK_RESET;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.result;
      if (tick_we) tick_amount <= tick_wdata;
      if (cmd.exec) begin
        case (cmd_r)
          CMD_ADD_READY: begin
            if (prio_r != LVL_NONE && rq_cnt[a_q] != RFULL)
              rq_cnt[a_q] <= rq_cnt[a_q] + RCW'(1);
          end
          CMD_ADD_BLOCKED: begin
            if (prio_r != LVL_NONE && bcount != BFULL) bcount <= bcount + BCW'(1);
          end
          CMD_ADVANCE: cur_time <= time_sum[48] ? TIME_MAX : time_sum[47:0];
          default: ;
        endcase
      end
      if (cmd.tick) cur_time <= time_sum[48] ? TIME_MAX : time_sum[47:0];
      if (cmd.scan_step && s_exp && s_lvl != LVL_NONE && rq_cnt[s_q] != RFULL)
        rq_cnt[s_q] <= rq_cnt[s_q] + RCW'(1);
      if (cmd.compact && (rd_i + BCW'(1) == bcount)) begin
        // Last entry handled this cycle; survivor count settles below.
        bcount <= (gone[BAW'(rd_i)]) ? wr_i : wr_i + BCW'(1);
      end
      if (cmd.grant && g_lvl != LVL_NONE) begin
        rq_cnt[g_q]  <= rq_cnt[g_q] - RCW'(1);
        rq_head[g_q] <= (rq_head[g_q] == RLAST) ? '0 : rq_head[g_q] + RAW'(1);
        slot <= (slot == SLOT_COUNT - 3'd1) ? 3'd0 : slot + 3'd1;
      end
    end
  end

  // Payload registers and memories.
  logic [RCW:0] a_pos, s_pos;
  assign a_pos = {1'b0, RCW'(rq_head[a_q])} + {1'b0, rq_cnt[a_q]};
  assign s_pos = {1'b0, RCW'(rq_head[s_q])} + {1'b0, rq_cnt[s_q]};
  logic [RAW-1:0] a_idx, s_idx;
  assign a_idx = (a_pos >= (RCW+1)'(READY_DEPTH)) ? RAW'(a_pos - (RCW+1)'(READY_DEPTH))
                                                  : RAW'(a_pos);
  assign s_idx = (s_pos >= (RCW+1)'(READY_DEPTH)) ? RAW'(s_pos - (RCW+1)'(READY_DEPTH))
                                                  : RAW'(s_pos);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= command; pid_r <= process_id; prio_r <= priority_req;
      wake_r <= wake_time; amt_r <= time_amount;
      lost <= 1'b0; landed <= '0; granted <= 1'b0; gid <= '0; glvl <= LVL_NONE;
    end
    if (cmd.exec) begin
      case (cmd_r)
        CMD_ADD_READY: begin
          if (prio_r == LVL_NONE || rq_cnt[a_q] == RFULL) lost <= 1'b1;
          else rq_mem[a_q][a_idx] <= pid_r;
        end
        CMD_ADD_BLOCKED: begin
          if (prio_r == LVL_NONE || bcount == BFULL) begin
            lost <= 1'b1;
          end else begin
            bs_id[BAW'(bcount)] <= pid_r;
            bs_lvl[BAW'(bcount)] <= prio_r;
            bs_wake[BAW'(bcount)] <= wake_r;
          end
        end
        default: ;
      endcase
    end
    if (cmd.scan_init) begin
      scan_i <= bcount; scan_n <= bcount; gone <= '0; rd_i <= '0; wr_i <= '0;
    end
    if (cmd.scan_step) begin
      scan_i <= scan_i - BCW'(1);
      if (s_exp) begin
        gone[sk] <= 1'b1;
        if (s_lvl != LVL_NONE && rq_cnt[s_q] != RFULL) begin
          rq_mem[s_q][s_idx] <= bs_id[sk];
          if (landed != 5'd31) landed <= landed + 5'd1;
        end else begin
          lost <= 1'b1;
        end
      end
    end
    if (cmd.compact) begin
      rd_i <= rd_i + BCW'(1);
      if (!gone[BAW'(rd_i)]) begin
        bs_id[BAW'(wr_i)]   <= bs_id[BAW'(rd_i)];
        bs_lvl[BAW'(wr_i)]  <= bs_lvl[BAW'(rd_i)];
        bs_wake[BAW'(wr_i)] <= bs_wake[BAW'(rd_i)];
        wr_i <= wr_i + BCW'(1);
      end
    end
    if (cmd.grant && g_lvl != LVL_NONE) begin
      granted <= 1'b1;
      glvl <= g_lvl;
      gid <= rq_mem[g_q][rq_head[g_q]];
    end
  end

  // Result outputs.
  always_ff @(posedge clk) begin
    if (cmd.result) begin
      grant_valid <= granted;
      granted_id <= gid;
      granted_level <= glvl;
      released_count <= landed;
      dropped <= lost;
      all_empty <= (bcount == '0) && (rq_cnt[0] == '0) && (rq_cnt[1] == '0) &&
                   (rq_cnt[2] == '0);
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/weighted_three_level_scheduler.sv -----
// Top level of the weighted three-level scheduler.
// Joins wtls_ctrl and wtls_dp; depends on wtls_pkg.
//
// Usage: drive command, process_id, priority_req, wake_time and time_amount
// with start high while busy is low; the item is taken at that edge and the
// inputs need not be held afterwards. Each item yields one result, shown for
// exactly one cycle with done high; the receiver cannot stall it.
// add_ready, add_blocked and advance_time pass through the execute and done
// states. A schedule item passes through the tick, scan, compaction, grant
// and done states; every blocked-store entry present before the item is
// examined once during the release scan (newest first) and once more
// during compaction, where survivors move down one per cycle.
// Busy drops in the cycle where done is high, so the next item can be taken
// at the same edge that takes the result.
// The tick_amount register is written by tick_we/tick_wdata; the user must write it only while idle (not enforced).
// Reset (rst, synchronous) empties all queues and the blocked store, clears
// the clock and the slot counter, and loads tick_amount with 1000000.
`default_nettype none
module weighted_three_level_scheduler import wtls_pkg::*; #(
  parameter int READY_DEPTH   = 16,
  parameter int BLOCKED_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  command,
  input  wire logic [15:0] process_id,
  input  wire logic [1:0]  priority_req,
  input  wire logic [47:0] wake_time,
  input  wire logic [31:0] time_amount,
  input  wire logic        tick_we,
  input  wire logic [31:0] tick_wdata,
  output logic             done,
  output logic             grant_valid,
  output logic [15:0]      granted_id,
  output logic [1:0]       granted_level,
  output logic [4:0]       released_count,
  output logic             dropped,
  output logic             all_empty
);
  wtls_cmd_t cmd;
  wtls_sts_t sts;

  // Sequencer.
  wtls_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .command(command),
    .sts(sts), .busy(busy), .cmd(cmd)
  );

  // Queues, store and clock.
  wtls_dp #(.READY_DEPTH(READY_DEPTH), .BLOCKED_DEPTH(BLOCKED_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .tick_we(tick_we), .tick_wdata(tick_wdata),
    .command(command), .process_id(process_id), .priority_req(priority_req),
    .wake_time(wake_time), .time_amount(time_amount),
    .result_valid(done), .grant_valid(grant_valid), .granted_id(granted_id),
    .granted_level(granted_level), .released_count(released_count),
    .dropped(dropped), .all_empty(all_empty)
  );
endmodule
`default_nettype wire

// ----- verif/weighted_three_level_scheduler_tb.sv -----
// Self-checking testbench for the weighted three-level scheduler.
// Drives directed and random items, predicts each result with a behavioral
// model of the queues, blocked store and slot counter; depends on wtls_pkg.
module weighted_three_level_scheduler_tb;
  import wtls_pkg::*;

  localparam int QDEPTH = 16;
  localparam int BDEPTH = 16;
  localparam int STALL_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  command = CMD_ADD_READY;
  logic [15:0] process_id = '0;
  logic [1:0]  priority_req = LVL_NONE;
  logic [47:0] wake_time = '0;
  logic [31:0] time_amount = '0;
  logic        tick_we = 1'b0;
  logic [31:0] tick_wdata = '0;
  logic        done;
  logic        grant_valid;
  logic [15:0] granted_id;
  logic [1:0]  granted_level;
  logic [4:0]  released_count;
  logic        dropped;
  logic        all_empty;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] pid;
    logic [1:0]  prio;
    logic [47:0] wake;
    logic [31:0] amount;
  } sched_item_t;

  typedef struct packed {
    logic        gvalid;
    logic [15:0] gid;
    logic [1:0]  glevel;
    logic [4:0]  released;
    logic        lost;
    logic        empty;
  } sched_result_t;

  // Directed row: an item, and optionally a result typed in by hand.
  typedef struct packed {
    sched_item_t   item;
    logic          fixed;
    sched_result_t res;
  } directed_row_t;

  // Predictor state.
  logic [15:0] ready_q[3][$];
  logic [15:0] blk_pid[$];
  logic [1:0]  blk_lvl[$];
  logic [47:0] blk_wake[$];
  logic [47:0] sim_clock;
  int unsigned slot;
  logic [31:0] tick_amt;

  sched_result_t pending_results[$];
  int errors = 0;
  int idle_cycles = 0;
  bit feeding = 1'b1;

  weighted_three_level_scheduler dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .process_id(process_id), .priority_req(priority_req),
    .wake_time(wake_time), .time_amount(time_amount),
    .tick_we(tick_we), .tick_wdata(tick_wdata), .done(done),
    .grant_valid(grant_valid), .granted_id(granted_id),
    .granted_level(granted_level), .released_count(released_count),
    .dropped(dropped), .all_empty(all_empty)
  );

  always #5 clk = ~clk;

  task automatic report(input string what, input logic [47:0] got,
                        input logic [47:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic void clock_add(input logic [47:0] amt);
    logic [48:0] s;
    s = {1'b0, sim_clock} + {1'b0, amt};
    sim_clock = s[48] ? TIME_MAX : s[47:0];
  endfunction

  function automatic bit push_ready(input logic [1:0] lvl, input logic [15:0] id);
    if (lvl == LVL_NONE) return 1'b0;
    if (ready_q[lvl - 1].size() >= QDEPTH) return 1'b0;
    ready_q[lvl - 1].push_back(id);
    return 1'b1;
  endfunction

  // Compute the result of one item and advance the predictor state.
  function automatic sched_result_t schedule_outcome(input sched_item_t it);
    sched_result_t r;
    logic [1:0] order[3];
    r = '0;
    case (it.cmd)
      CMD_ADD_READY: begin
        if (!push_ready(it.prio, it.pid)) r.lost = 1'b1;
      end
      CMD_ADD_BLOCKED: begin
        if (it.prio == LVL_NONE || blk_pid.size() >= BDEPTH) r.lost = 1'b1;
        else begin
          blk_pid.push_back(it.pid);
          blk_lvl.push_back(it.prio);
          blk_wake.push_back(it.wake);
        end
      end
      CMD_SCHEDULE: begin
        clock_add({16'd0, tick_amt});
        // Release expired entries, newest first; survivors keep their order.
        for (int k = blk_pid.size() - 1; k >= 0; k--) begin
          if (blk_wake[k] <= sim_clock) begin
            if (push_ready(blk_lvl[k], blk_pid[k])) begin
              if (r.released != 5'd31) r.released++;
            end else r.lost = 1'b1;
            blk_pid.delete(k);
            blk_lvl.delete(k);
            blk_wake.delete(k);
          end
        end
        if (slot < HIGH_SLOTS) order = '{LVL_HIGH, LVL_MEDIUM, LVL_LOW};
        else order = '{LVL_MEDIUM, LVL_LOW, LVL_HIGH};
        for (int j = 0; j < 3 && !r.gvalid; j++) begin
          if (ready_q[order[j] - 1].size() > 0) begin
            r.gvalid = 1'b1;
            r.gid = ready_q[order[j] - 1].pop_front();
            r.glevel = order[j];
          end
        end
        if (r.gvalid) slot = (slot + 1) % SLOT_COUNT;
      end
      default: clock_add({16'd0, it.amount});
    endcase
    r.empty = (blk_pid.size() == 0 && ready_q[0].size() == 0 &&
               ready_q[1].size() == 0 && ready_q[2].size() == 0);
    return r;
  endfunction

  // Check each strobed result against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("unexpected result at %0t", $time);
        errors++;
      end else begin
        sched_result_t w;
        w = pending_results.pop_front();
        if (grant_valid !== w.gvalid)
          report("grant_valid", 48'(grant_valid), 48'(w.gvalid));
        if (granted_id !== w.gid) report("granted_id", 48'(granted_id), 48'(w.gid));
        if (granted_level !== w.glevel)
          report("granted_level", 48'(granted_level), 48'(w.glevel));
        if (released_count !== w.released)
          report("released_count", 48'(released_count), 48'(w.released));
        if (dropped !== w.lost) report("dropped", 48'(dropped), 48'(w.lost));
        if (all_empty !== w.empty) report("all_empty", 48'(all_empty), 48'(w.empty));
      end
    end
  end

  // Watchdog on cycles with no accepted item or result.
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else if (feeding || pending_results.size() > 0) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Present one item, wait for acceptance, then wait a random gap.
  // With no gap, start stays high for the next item.
  task automatic send_item(input sched_item_t it, input bit fixed,
                           input sched_result_t want);
    sched_result_t r;
    int gap;
    command <= it.cmd;
    process_id <= it.pid;
    priority_req <= it.prio;
    wake_time <= it.wake;
    time_amount <= it.amount;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    r = schedule_outcome(it);
    pending_results.push_back(fixed ? want : r);
    gap = $urandom_range(0, 9);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_and_write(input logic [31:0] val);
    start <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    tick_we <= 1'b1;
    tick_wdata <= val;
    @(posedge clk);
    tick_we <= 1'b0;
    tick_amt = val;
  endtask

  function automatic sched_item_t random_item();
    sched_item_t it;
    int sel;
    it.pid = 16'($urandom);
    it.amount = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3000000);
    sel = $urandom_range(0, 99);
    it.cmd = (sel < 35) ? CMD_ADD_READY : (sel < 55) ? CMD_ADD_BLOCKED :
             (sel < 90) ? CMD_SCHEDULE : CMD_ADVANCE;
    it.prio = ($urandom_range(0, 15) == 0) ? LVL_NONE : 2'($urandom_range(1, 3));
    // Wake times mostly near the clock so releases happen; some far out.
    case ($urandom_range(0, 3))
      0: it.wake = 48'({$urandom, $urandom});
      1: it.wake = sim_clock;
      default: it.wake = sim_clock + 48'($urandom_range(0, 8000000));
    endcase
    return it;
  endfunction

  directed_row_t rows[$];

  function automatic directed_row_t mk(input logic [1:0] c, input logic [15:0] p,
      input logic [1:0] pr, input logic [47:0] wk, input logic [31:0] am,
      input bit fx, input sched_result_t res);
    directed_row_t d;
    d.item = '{cmd: c, pid: p, prio: pr, wake: wk, amount: am};
    d.fixed = fx;
    d.res = res;
    return d;
  endfunction

  initial begin
    sim_clock = '0;
    slot = 0;
    tick_amt = TICK_RESET;
    // Schedule on an empty block after reset: no grant, still empty.
    rows.push_back(mk(CMD_SCHEDULE, 0, LVL_NONE, 0, 0, 1,
                      '{1'b0, 16'd0, LVL_NONE, 5'd0, 1'b0, 1'b1}));
    // Invalid priority is dropped.
    rows.push_back(mk(CMD_ADD_READY, 16'hFFFF, LVL_NONE, 0, 0, 1,
                      '{1'b0, 16'd0, LVL_NONE, 5'd0, 1'b1, 1'b1}));
    rows.push_back(mk(CMD_ADD_BLOCKED, 16'h1234, LVL_NONE, TIME_MAX, 0, 1,
                      '{1'b0, 16'd0, LVL_NONE, 5'd0, 1'b1, 1'b1}));
    rows.push_back(mk(CMD_ADD_READY, 16'hFFFF, LVL_HIGH, 0, 0, 0, '0));
    rows.push_back(mk(CMD_ADD_READY, 16'h0000, LVL_MEDIUM, 0, 0, 0, '0));
    rows.push_back(mk(CMD_ADD_READY, 16'hA5A5, LVL_LOW, 0, 0, 0, '0));
    rows.push_back(mk(CMD_ADD_BLOCKED, 16'h5A5A, LVL_LOW, 48'd1500000, 0, 0, '0));
    rows.push_back(mk(CMD_ADD_BLOCKED, 16'h0F0F, LVL_HIGH, TIME_MAX, 0, 0, '0));
    rows.push_back(mk(CMD_ADD_BLOCKED, 16'hF0F0, LVL_MEDIUM, 48'd0, 0, 0, '0));
    for (int i = 0; i < 5; i++) rows.push_back(mk(CMD_SCHEDULE, 0, 0, 0, 0, 0, '0));
    rows.push_back(mk(CMD_ADVANCE, 0, 0, 0, 32'hFFFF_FFFF, 0, '0));
    rows.push_back(mk(CMD_ADVANCE, 0, 0, 0, 32'd0, 0, '0));
    for (int i = 0; i < 3; i++) rows.push_back(mk(CMD_SCHEDULE, 0, 0, 0, 0, 0, '0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send_item(rows[i].item, rows[i].fixed, rows[i].res);

    // Fill a ready queue and the blocked store past capacity.
    for (int i = 0; i < QDEPTH + 2; i++)
      send_item('{CMD_ADD_READY, 16'(i), LVL_HIGH, 48'd0, 32'd0}, 0, '0);
    for (int i = 0; i < BDEPTH + 2; i++)
      send_item('{CMD_ADD_BLOCKED, 16'(i + 100), LVL_HIGH, 48'd0, 32'd0}, 0, '0);
    send_item('{CMD_SCHEDULE, 16'd0, LVL_NONE, 48'd0, 32'd0}, 0, '0);

    // Maximum advance amounts, then a schedule with maximum tick.
    drain_and_write(32'hFFFF_FFFF);
    for (int i = 0; i < 3; i++)
      send_item('{CMD_ADVANCE, 16'd0, LVL_NONE, 48'd0, 32'hFFFF_FFFF}, 0, '0);
    send_item('{CMD_SCHEDULE, 16'd0, LVL_NONE, 48'd0, 32'd0}, 0, '0);

    // Random phases under several tick settings; the first write at zero.
    for (int ph = 0; ph < 4; ph++) begin
      drain_and_write(ph == 0 ? 32'd0 : ph == 1 ? TICK_RESET :
                      ph == 2 ? 32'hFFFF_FFFF : $urandom_range(1, 5000000));
      for (int n = 0; n < 200; n++) send_item(random_item(), 0, '0);
    end

    start <= 1'b0;
    feeding = 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
